### rtl/core/wsfd_pkg.sv
// wsfd_pkg: types, constants and the action_of helper shared by the frame deframer modules.
// No dependencies.
`default_nettype none

package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_FIRST = 3'd0,
    PH_LEN   = 3'd1,
    PH_EXT   = 3'd2,
    PH_MASK  = 3'd3,
    PH_DATA  = 3'd4
  } parse_phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_OVERSIZE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ACT_DELIVER     = 3'd0,
    ACT_PONG        = 3'd1,
    ACT_DROP        = 3'd2,
    ACT_CLOSE_ECHO  = 3'd3,
    ACT_CLOSE_QUIET = 3'd4
  } action_t;

  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [2:0] EXT16_CNT  = 3'd1;
  localparam logic [2:0] EXT64_CNT  = 3'd7;
  localparam logic [2:0] KEY_CNT    = 3'd3;

  localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [3:0]  opcode;
    action_t     action;
    logic        is_binary;
    logic        last;
  } wsfd_result_t;

  typedef struct packed {
    logic halted;
    logic in_payload;
  } wsfd_status_t;

  function automatic action_t action_of(logic [3:0] op, logic closing);
    action_t a;
    unique case (op)
      OP_TEXT, OP_BIN: a = ACT_DELIVER;
      OP_PING:         a = ACT_PONG;
      OP_CLOSE:        a = closing ? ACT_CLOSE_QUIET : ACT_CLOSE_ECHO;
      default:         a = ACT_DROP;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### rtl/core/websocket_frame_deframer_top.sv
// websocket_frame_deframer_top: byte-serial WebSocket frame deframer.
// Depends on wsfd_pkg and wsfd_parser.
//
// Usage:
//   Input channel (in_valid/in_ready): one received stream byte per request,
//   with client_closing sampled alongside it.
//   Output channel (out_valid/out_ready): one result per payload byte, one
//   marker per empty frame, or one oversize error. Header bytes give none.
//   Config: APB register 0 at address 0 is max_frame_len (reset 1048576).
//   Results: each result is registered and appears in the cycle after the byte that caused it.
//   Throughput: one byte per cycle; a new byte is taken while a result sits
//   in the output register as long as out_ready is high in that cycle.
//   Stall: with out_ready low and a result held, in_ready drops until the
//   result is taken; nothing is lost or repeated.
//   Reset (rst, synchronous): parser returns to awaiting a first header
//   byte, output is emptied, max_frame_len returns to its reset value.
//   After a close frame or an oversize error all bytes are accepted and
//   discarded until reset.
`default_nettype none

module websocket_frame_deframer_top #(
  parameter int LEN_BITS = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  rx_byte,
  input  wire         client_closing,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  data,
  output logic [3:0]  opcode,
  output logic [2:0]  action,
  output logic        is_binary,
  output logic        last
);
  import wsfd_pkg::*;

  logic [31:0]  max_frame_len;
  logic         in_fire;
  logic         res_valid;
  wsfd_result_t res;
  wsfd_result_t res_q;
  wsfd_status_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      max_frame_len <= pwdata;
    end
  end

  assign prdata = paddr[2] ? 32'd0 : max_frame_len;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  wsfd_parser #(.LEN_BITS(LEN_BITS)) u_parser (
    .clk            (clk),
    .rst            (rst),
    .in_fire        (in_fire),
    .rx_byte        (rx_byte),
    .client_closing (client_closing),
    .max_frame_len  (max_frame_len),
    .res_valid      (res_valid),
    .res            (res),
    .status         (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && res_valid) begin
      res_q <= res;
    end
  end

  assign kind      = res_q.kind;
  assign data      = res_q.data;
  assign opcode    = res_q.opcode;
  assign action    = res_q.action;
  assign is_binary = res_q.is_binary;
  assign last      = res_q.last;

  a_result_needs_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_fire)
    else $error("result without an accepted byte");

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    status.halted |-> !res_valid)
    else $error("result produced while halted");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    status.halted |=> status.halted)
    else $error("halt cleared without reset");

  a_marker_ends_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind != KIND_PAYLOAD |-> res.last && res.data == 8'd0)
    else $error("marker or error not final or carries data");

endmodule

`default_nettype wire

### rtl/core/wsfd_parser.sv
// wsfd_parser: frame header state and per-byte result logic.
// Depends on wsfd_pkg.
`default_nettype none

module wsfd_parser #(
  parameter int LEN_BITS = 64
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_fire,
  input  wire  [7:0]            rx_byte,
  input  wire                   client_closing,
  input  wire  [31:0]           max_frame_len,
  output logic                  res_valid,
  output wsfd_pkg::wsfd_result_t res,
  output wsfd_pkg::wsfd_status_t status
);
  import wsfd_pkg::*;

  localparam int CMP_W = (LEN_BITS > 32) ? LEN_BITS : 32;

  parse_phase_t          phase, phase_next;
  logic [2:0]            cnt, cnt_next;
  logic [3:0]            frame_op, frame_op_next;
  logic                  mask_on, mask_on_next;
  logic [LEN_BITS-1:0]   remaining, remaining_next;
  logic                  len_ovf, len_ovf_next;
  logic [31:0]           key, key_next;
  logic [1:0]            key_idx, key_idx_next;
  logic                  halted, halted_next;

  logic [LEN_BITS-1:0]   ext_len;
  logic                  ext_ovf;
  logic [LEN_BITS-1:0]   hd_len;
  logic                  hd_ovf;
  logic                  too_long;
  logic                  finish;
  logic [LEN_BITS-1:0]   rem_dec;
  logic [7:0]            key_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FIRST;
      cnt       <= '0;
      frame_op  <= '0;
      mask_on   <= 1'b0;
      remaining <= '0;
      len_ovf   <= 1'b0;
      key       <= '0;
      key_idx   <= '0;
      halted    <= 1'b0;
    end else begin
      phase     <= phase_next;
      cnt       <= cnt_next;
      frame_op  <= frame_op_next;
      mask_on   <= mask_on_next;
      remaining <= remaining_next;
      len_ovf   <= len_ovf_next;
      key       <= key_next;
      key_idx   <= key_idx_next;
      halted    <= halted_next;
    end
  end

  // extended length shifts in a byte; anything pushed past LEN_BITS is sticky
  assign ext_len  = {remaining[LEN_BITS-9:0], rx_byte};
  assign ext_ovf  = len_ovf | (|remaining[LEN_BITS-1 -: 8]);
  assign rem_dec  = remaining - LEN_BITS'(1);
  assign key_byte = key[31 - 8*key_idx -: 8];

  always_comb begin
    unique case (phase)
      PH_LEN:  begin hd_len = LEN_BITS'(rx_byte[6:0]); hd_ovf = 1'b0; end
      PH_EXT:  begin hd_len = ext_len; hd_ovf = ext_ovf; end
      default: begin hd_len = remaining; hd_ovf = len_ovf; end
    endcase
  end

  assign too_long = hd_ovf | (CMP_W'(hd_len) > CMP_W'(max_frame_len));

  always_comb begin
    phase_next     = phase;
    cnt_next       = cnt;
    frame_op_next  = frame_op;
    mask_on_next   = mask_on;
    remaining_next = remaining;
    len_ovf_next   = len_ovf;
    key_next       = key;
    key_idx_next   = key_idx;
    halted_next    = halted;
    finish         = 1'b0;
    res_valid      = 1'b0;
    res.kind       = KIND_PAYLOAD;
    res.data       = '0;
    res.opcode     = frame_op;
    res.action     = action_of(frame_op, client_closing);
    res.is_binary  = (frame_op == OP_BIN);
    res.last       = 1'b0;

    if (in_fire && !halted) begin
      unique case (phase)
        PH_FIRST: begin
          frame_op_next = rx_byte[3:0];
          phase_next    = PH_LEN;
        end
        PH_LEN: begin
          mask_on_next   = rx_byte[7];
          key_next       = '0;
          len_ovf_next   = 1'b0;
          remaining_next = '0;
          if (rx_byte[6:0] == LEN7_EXT16 || rx_byte[6:0] == LEN7_EXT64) begin
            cnt_next   = (rx_byte[6:0] == LEN7_EXT16) ? EXT16_CNT : EXT64_CNT;
            phase_next = PH_EXT;
          end else if (rx_byte[7]) begin
            remaining_next = hd_len;
            cnt_next       = KEY_CNT;
            phase_next     = PH_MASK;
          end else begin
            finish = 1'b1;
          end
        end
        PH_EXT: begin
          remaining_next = ext_len;
          len_ovf_next   = ext_ovf;
          if (cnt != 3'd0) begin
            cnt_next = cnt - 3'd1;
          end else if (mask_on) begin
            cnt_next   = KEY_CNT;
            phase_next = PH_MASK;
          end else begin
            finish = 1'b1;
          end
        end
        PH_MASK: begin
          key_next = {key[23:0], rx_byte};
          if (cnt != 3'd0) begin
            cnt_next = cnt - 3'd1;
          end else begin
            finish = 1'b1;
          end
        end
        PH_DATA: begin
          res_valid      = 1'b1;
          res.data       = mask_on ? (rx_byte ^ key_byte) : rx_byte;
          res.last       = (rem_dec == '0);
          key_idx_next   = key_idx + 2'd1;
          remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = PH_FIRST;
            if (frame_op == OP_CLOSE) halted_next = 1'b1;
          end
        end
        default: begin
          phase_next = PH_FIRST;
        end
      endcase

      // header complete: oversize error on a failed length check, else payload or a single marker
      if (finish) begin
        remaining_next = hd_len;
        if (too_long) begin
          res_valid   = 1'b1;
          res.kind    = KIND_OVERSIZE;
          res.action  = ACT_DROP;
          res.last    = 1'b1;
          halted_next = 1'b1;
          phase_next  = PH_FIRST;
        end else if (hd_len == '0) begin
          key_idx_next = '0;
          res_valid    = 1'b1;
          res.kind     = KIND_EMPTY;
          res.last     = 1'b1;
          phase_next   = PH_FIRST;
          if (frame_op == OP_CLOSE) halted_next = 1'b1;
        end else begin
          key_idx_next = '0;
          phase_next   = PH_DATA;
        end
      end
    end
  end

  assign status.halted     = halted;
  assign status.in_payload = (phase == PH_DATA);

endmodule

`default_nettype wire
